### hdl/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Types and byte constants shared by the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

  localparam logic [7:0] CONT_LOW   = 8'h80;
  localparam logic [7:0] CONT_HIGH  = 8'hBF;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_LOW  = 8'hC2;
  localparam logic [7:0] LEAD2_HIGH = 8'hDF;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD3_HIGH = 8'hEF;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] E0_LOW     = 8'hA0;
  localparam logic [7:0] ED_HIGH    = 8'h9F;
  localparam logic [7:0] F0_LOW     = 8'h90;
  localparam logic [7:0] F4_HIGH    = 8'h8F;

  typedef logic [1:0] pend_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_word_t;

endpackage

### hdl/u8v_if.sv
// ----------------------------------------------------------------------------
// u8v_if
// Valid/ready channels for text bytes in and validation results out.
// ----------------------------------------------------------------------------
interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output has_byte, output is_last,
                  input ready);
  modport sink (input valid, input text_byte, input has_byte, input is_last,
                output ready);
endinterface

interface u8v_out_if;
  logic valid;
  logic ready;
  logic text_valid;

  modport source (output valid, output text_valid, input ready);
  modport sink (input valid, input text_valid, output ready);
endinterface

### hdl/u8v_in_stage.sv
// ----------------------------------------------------------------------------
// u8v_in_stage
// Input register: captures one word per cycle unless stalled, for the checker.
// ----------------------------------------------------------------------------
module u8v_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  u8v_in_if.sink             in_ch,
  input  logic               advance,
  output u8v_pkg::stage_word_t word
);
  import u8v_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.text_byte <= in_ch.text_byte;
      item_r.has_byte  <= in_ch.has_byte;
      item_r.is_last   <= in_ch.is_last;
    end
  end

  assign word.valid = valid_r;
  assign word.item  = item_r;

endmodule

### hdl/u8v_check.sv
// ----------------------------------------------------------------------------
// u8v_check
// Sequence tracker and result register: checks one byte per cycle or stalls.
// ----------------------------------------------------------------------------
module u8v_check (
  input  logic                clk,
  input  logic                rst_n,
  input  u8v_pkg::stage_word_t word,
  output logic                advance,
  u8v_out_if.source           out_ch
);
  import u8v_pkg::*;

  pend_t      pend_r, pend_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic       fault_r, fault_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       result_r, result_nxt;
  logic       take;
  logic [7:0] c;

  assign take    = word.valid && (!word.item.is_last || !out_valid_r || out_ch.ready);
  assign advance = take;
  assign c       = word.item.text_byte;

  always_comb begin
    pend_nxt   = pend_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    fault_nxt  = fault_r;
    result_nxt = result_r;
    if (take && word.item.has_byte) begin
      if (pend_r != 2'd0) begin
        if (c >= lo_r && c <= hi_r) begin
          pend_nxt = pend_r - 2'd1;
          lo_nxt   = CONT_LOW;
          hi_nxt   = CONT_HIGH;
        end else begin
          fault_nxt = 1'b1;
          pend_nxt  = 2'd0;
          lo_nxt    = CONT_LOW;
          hi_nxt    = CONT_HIGH;
        end
      end else if (c == 8'h00) begin
        fault_nxt = 1'b1;
      end else if (c <= ASCII_MAX) begin
        pend_nxt = 2'd0;
      end else if (c >= LEAD2_LOW && c <= LEAD2_HIGH) begin
        pend_nxt = 2'd1;
      end else if (c == LEAD_E0) begin
        pend_nxt = 2'd2;
        lo_nxt   = E0_LOW;
      end else if (c == LEAD_ED) begin
        pend_nxt = 2'd2;
        hi_nxt   = ED_HIGH;
      end else if (c > LEAD_E0 && c <= LEAD3_HIGH) begin
        pend_nxt = 2'd2;
      end else if (c == LEAD_F0) begin
        pend_nxt = 2'd3;
        lo_nxt   = F0_LOW;
      end else if (c == LEAD_F4) begin
        pend_nxt = 2'd3;
        hi_nxt   = F4_HIGH;
      end else if (c > LEAD_F0 && c < LEAD_F4) begin
        pend_nxt = 2'd3;
      end else begin
        fault_nxt = 1'b1;
      end
    end
    if (take && word.item.is_last) begin
      result_nxt = !fault_nxt && (pend_nxt == 2'd0);
      pend_nxt   = 2'd0;
      lo_nxt     = CONT_LOW;
      hi_nxt     = CONT_HIGH;
      fault_nxt  = 1'b0;
    end
  end

  assign out_valid_nxt = (take && word.item.is_last) || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 2'd0;
      lo_r        <= CONT_LOW;
      hi_r        <= CONT_HIGH;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.text_valid = result_r;

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && word.item.is_last |=> pend_r == 2'd0 && !fault_r && lo_r == CONT_LOW
      && hi_r == CONT_HIGH)
    else $error("state not cleared after last word");

  a_bounds_sane: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r >= CONT_LOW && hi_r <= CONT_HIGH && lo_r <= hi_r)
    else $error("continuation bounds out of range");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take && word.item.is_last))
    else $error("result raised without a last word");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !(take && word.item.is_last))
    else $error("last word taken while result stalled");
`endif

endmodule

### hdl/utf8_stream_validator.sv
// A last word crosses the input register and the result register to out_ch.
// Throughput: one word per cycle; the result register frees the input side.
// A last word stalls only while an earlier result waits to be taken.
// Reset: synchronous, active low; clears sequence state and both valid flags.
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 checker with NUL rejection, at most one text byte per word.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
  input  logic       clk,
  input  logic       rst_n,
  u8v_in_if.sink     in_ch,
  u8v_out_if.source  out_ch
);
  import u8v_pkg::*;

  stage_word_t word;
  logic        advance;

  u8v_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .word    (word)
  );

  u8v_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .word    (word),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

### tb/sv/tb_utf8_stream_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_validator
// Self-checking bench for the strict UTF-8 stream validator. A directed table
// covers empty texts, NUL, bad leads, narrowed continuation ranges, open
// sequences and sticky faults. Random texts follow: mostly well-formed with
// some corruption, run under several sender/receiver idling mixes and one long
// receiver hold-off. Results are checked against pinned values or a predictor.
// ----------------------------------------------------------------------------
module tb_utf8_stream_validator;
  import u8v_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         PHASE_ITEMS  = 275;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [7:0] NUL_BYTE     = 8'h00;

  typedef struct packed {
    item_t w;
    logic  pinned;
    logic  pinned_val;
  } stim_t;

  typedef struct packed {
    logic [7:0] b;
    logic       has;
    logic       last;
    logic       pinned;
    logic       val;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  u8v_in_if  in_ch ();
  u8v_out_if out_ch ();

  utf8_stream_validator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_t      word_q[$];
  logic       verdict_q[$];
  int         errors     = 0;
  int         cycle_cnt  = 0;
  int         idle_pct   = 0;
  int         stall_pct  = 0;
  logic       hold_off   = 1'b0;
  logic       hold_go    = 1'b0;

  pend_t      utf8_pending = '0;
  logic [7:0] utf8_lo      = CONT_LOW;
  logic [7:0] utf8_hi      = CONT_HIGH;
  logic       utf8_fault   = 1'b0;

  row_t dir_rows [0:24] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
    '{8'h41, 1'b1, 1'b1, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 1'b1, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0},
    '{8'hC1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
    '{8'hC2, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hBF, 1'b1, 1'b1, 1'b0, 1'b0},
    '{8'hE0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h9F, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
    '{8'hED, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h9F, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'hBF, 1'b1, 1'b1, 1'b0, 1'b0},
    '{8'hF0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h90, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
    '{8'hF4, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h90, 1'b1, 1'b1, 1'b1, 1'b0},
    '{8'hE1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{8'hF5, 1'b1, 1'b0, 1'b0, 1'b0},
    '{8'h41, 1'b1, 1'b1, 1'b1, 1'b0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  // UTF-8 predictor state handling
  task automatic utf8_open(input pend_t n, input logic [7:0] lo, input logic [7:0] hi);
    utf8_pending = n;
    utf8_lo      = lo;
    utf8_hi      = hi;
  endtask

  task automatic utf8_abort();
    utf8_fault = 1'b1;
    utf8_open(2'd0, CONT_LOW, CONT_HIGH);
  endtask

  task automatic utf8_take(input logic [7:0] c);
    if (utf8_pending != 2'd0) begin
      if (c >= utf8_lo && c <= utf8_hi) begin
        utf8_open(utf8_pending - 2'd1, CONT_LOW, CONT_HIGH);
      end else begin
        utf8_abort();
      end
    end else if (c == NUL_BYTE) begin
      utf8_abort();
    end else if (c <= ASCII_MAX) begin
    end else if (c >= LEAD2_LOW && c <= LEAD2_HIGH) begin
      utf8_open(2'd1, CONT_LOW, CONT_HIGH);
    end else if (c == LEAD_E0) begin
      utf8_open(2'd2, E0_LOW, CONT_HIGH);
    end else if (c == LEAD_ED) begin
      utf8_open(2'd2, CONT_LOW, ED_HIGH);
    end else if (c > LEAD_E0 && c <= LEAD3_HIGH) begin
      utf8_open(2'd2, CONT_LOW, CONT_HIGH);
    end else if (c == LEAD_F0) begin
      utf8_open(2'd3, F0_LOW, CONT_HIGH);
    end else if (c == LEAD_F4) begin
      utf8_open(2'd3, CONT_LOW, F4_HIGH);
    end else if (c > LEAD_F0 && c < LEAD_F4) begin
      utf8_open(2'd3, CONT_LOW, CONT_HIGH);
    end else begin
      utf8_abort();
    end
  endtask

  task automatic utf8_word(input item_t w, output logic got, output logic verdict);
    got     = 1'b0;
    verdict = 1'b0;
    if (w.has_byte) utf8_take(w.text_byte);
    if (w.is_last) begin
      got        = 1'b1;
      verdict    = !utf8_fault && utf8_pending == 2'd0;
      utf8_fault = 1'b0;
      utf8_open(2'd0, CONT_LOW, CONT_HIGH);
    end
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(CONT_LOW, CONT_HIGH));
  endfunction

  task automatic push_word(input logic [7:0] b, input logic has, input logic last);
    stim_t s;
    s.w.text_byte = b;
    s.w.has_byte  = has;
    s.w.is_last   = last;
    s.pinned      = 1'b0;
    s.pinned_val  = 1'b0;
    word_q.push_back(s);
  endtask

  // build one random text, mostly well-formed, and queue its words
  task automatic queue_text(output int counted);
    logic [7:0] txt[$];
    logic [7:0] lead;
    logic [7:0] bad;
    int         n_chars;
    logic       sep_end;
    counted = 0;
    n_chars = $urandom_range(0, 6);
    for (int k = 0; k < n_chars; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: txt.push_back(8'($urandom_range(1, ASCII_MAX)));
        3: begin
          txt.push_back(8'($urandom_range(LEAD2_LOW, LEAD2_HIGH)));
          txt.push_back(rand_cont());
        end
        4: begin
          txt.push_back(LEAD_E0);
          txt.push_back(8'($urandom_range(E0_LOW, CONT_HIGH)));
          txt.push_back(rand_cont());
        end
        5: begin
          txt.push_back(LEAD_ED);
          txt.push_back(8'($urandom_range(CONT_LOW, ED_HIGH)));
          txt.push_back(rand_cont());
        end
        6: begin
          lead = 8'($urandom_range(LEAD_E0 + 1, LEAD3_HIGH));
          if (lead == LEAD_ED) lead = LEAD_ED - 8'd1;
          txt.push_back(lead);
          txt.push_back(rand_cont());
          txt.push_back(rand_cont());
        end
        7: begin
          txt.push_back(LEAD_F0);
          txt.push_back(8'($urandom_range(F0_LOW, CONT_HIGH)));
          txt.push_back(rand_cont());
          txt.push_back(rand_cont());
        end
        8: begin
          txt.push_back(8'($urandom_range(LEAD_F0 + 1, LEAD_F4 - 1)));
          txt.push_back(rand_cont());
          txt.push_back(rand_cont());
          txt.push_back(rand_cont());
        end
        default: begin
          txt.push_back(LEAD_F4);
          txt.push_back(8'($urandom_range(CONT_LOW, F4_HIGH)));
          txt.push_back(rand_cont());
          txt.push_back(rand_cont());
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          if (txt.size() != 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
          else txt.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          if (txt.size() != 0) void'(txt.pop_back());
          else txt.push_back(rand_cont());
        end
        2: txt.insert($urandom_range(0, txt.size()), rand_cont());
        default: begin
          case ($urandom_range(0, 2))
            0:       bad = NUL_BYTE;
            1:       bad = 8'($urandom_range(8'hC0, 8'hC1));
            default: bad = 8'($urandom_range(LEAD_F4 + 1, 8'hFF));
          endcase
          txt.insert($urandom_range(0, txt.size()), bad);
        end
      endcase
    end
    sep_end = (txt.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (txt[i]) begin
      if ($urandom_range(0, 19) == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_word(txt[i], 1'b1, !sep_end && i == txt.size() - 1);
      counted++;
    end
    if (sep_end) begin
      push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      counted++;
    end
  endtask

  // sender: hold the offered word until taken, then advance
  initial begin
    stim_t acc;
    logic  got;
    logic  verdict;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.has_byte  = 1'b0;
    in_ch.is_last   = 1'b0;
    forever begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        acc = word_q.pop_front();
        utf8_word(acc.w, got, verdict);
        if (got) verdict_q.push_back(acc.pinned ? acc.pinned_val : verdict);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rst_n && word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.text_byte <= word_q[0].w.text_byte;
          in_ch.has_byte  <= word_q[0].w.has_byte;
          in_ch.is_last   <= word_q[0].w.is_last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // long receiver hold-off so the result path backs up into the input
  initial begin
    int n;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    logic exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual text_valid=%0b",
                 $time, out_ch.text_valid);
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_ch.text_valid !== exp_v) begin
          errors++;
          $display("%0t: text_valid mismatch, expected %0b, actual %0b",
                   $time, exp_v, out_ch.text_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL utf8_stream_validator");
      $finish;
    end
  end

  initial begin
    stim_t     s;
    int        counted;
    int        total;
    static int idle_tab  [4] = '{0, 88, 0, 13};
    static int stall_tab [4] = '{0, 0, 88, 13};
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      s.w.text_byte = dir_rows[i].b;
      s.w.has_byte  = dir_rows[i].has;
      s.w.is_last   = dir_rows[i].last;
      s.pinned      = dir_rows[i].pinned;
      s.pinned_val  = dir_rows[i].val;
      word_q.push_back(s);
    end
    hold_go <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      idle_pct  <= idle_tab[ph];
      stall_pct <= stall_tab[ph];
      total = 0;
      while (total < PHASE_ITEMS) begin
        queue_text(counted);
        total += counted;
      end
      while (word_q.size() != 0) @(posedge clk);
    end
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS utf8_stream_validator");
    end else begin
      $display("FAIL utf8_stream_validator");
    end
    $finish;
  end

endmodule
